[rtl/core/timed_event_scheduler_unit_defines.svh]
// assertion macros for the event scheduler
`ifndef TIMED_EVENT_SCHEDULER_UNIT_DEFINES_SVH
`define TIMED_EVENT_SCHEDULER_UNIT_DEFINES_SVH

`define TES_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("lbl failed");

`define TES_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("lbl failed");

`endif

[rtl/core/tes_pkg.sv]
package tes_pkg;

  localparam int EVENT_TYPES = 16;
  localparam int TYPE_W = $clog2(EVENT_TYPES);
  localparam int CNT_W = $clog2(EVENT_TYPES + 1);
  localparam logic [19:0] SLICE_LIMIT = 20'd1000000;
  localparam int ENTRY_W = 192;

  typedef enum logic [1:0] {
    OP_SCHEDULE = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_SLICE    = 2'd2,
    OP_ADVANCE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_GRANT = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic {
    REG_SLICE_CAP = 1'b0,
    REG_TYPES     = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_FIRE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         slot_type;
    logic signed [63:0] delay;
    logic [63:0]        user_value;
    logic signed [31:0] cycles_left;
    logic signed [31:0] exit_loss;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [19:0] grant;
    logic [3:0]  fired_type;
    logic [63:0] fired_value;
    logic [19:0] lateness;
    logic [63:0] time_now;
    logic        last;
  } out_beat_t;

endpackage

[rtl/core/tes_ram.sv]
module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/tes_regs.sv]
module tes_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:2]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [30:0] slice_cap,
  output logic [4:0]  types_in_use
);
  import tes_pkg::*;

  logic [30:0] cap_r;
  logic [4:0]  types_r;
  logic        wr;

  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign slice_cap = cap_r;
  assign types_in_use = types_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= '0;
      types_r <= '0;
    end else if (wr) begin
      case (reg_idx_t'(cfg_paddr[2]))
        REG_SLICE_CAP: cap_r   <= cfg_pwdata[30:0];
        REG_TYPES:     types_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[2]))
      REG_SLICE_CAP: cfg_prdata = {1'b0, cap_r};
      REG_TYPES:     cfg_prdata = {27'd0, types_r};
      default:       cfg_prdata = '0;
    endcase
  end
endmodule

[rtl/core/timed_event_scheduler_unit.sv]
// timed event scheduler
// in_ channel: one beat per operation (schedule, remove, slice, advance).
// out_ channel: result beats; last marks the final beat of an operation.
// schedule and remove give no result.
// slice: one scan of the slot memory, one read per cycle, then the grant beat.
// advance: a charge step, then one scan per fired event and a final
// scan that fires none before the done beat.
// a new beat can be taken in the cycle after the last result beat is taken.
// pending flags sit in flops cleared at reset; slot data lives in a
// single-port-read ram and is undefined until scheduled.
// reset clears time, grant, stamp counter and pending flags; no clearing pass.
// a stalled receiver holds the result register and ST_SCAN_WAIT waits;
// no new operation is taken until all beats of the current one are taken.
// cfg_ is an apb-style register port, slice_cap at 0x0, types_in_use at 0x4.
module timed_event_scheduler_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tes_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tes_pkg::out_beat_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:2]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import tes_pkg::*;
  `include "timed_event_scheduler_unit_defines.svh"

  logic [30:0] slice_cap;
  logic [4:0]  types_in_use;

  tes_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .slice_cap, .types_in_use
  );

  state_t state_r, state_nxt;
  in_beat_t op_r, op_nxt;
  logic [63:0] now_r, now_nxt;
  logic [19:0] budget_r, budget_nxt;
  logic [63:0] stamp_r, stamp_nxt;
  logic [EVENT_TYPES-1:0] pend_r, pend_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [TYPE_W-1:0] ridx_r, ridx_nxt;
  logic rvalid_r, rvalid_nxt;
  logic found_r, found_nxt;
  logic [TYPE_W-1:0] best_r, best_nxt;
  logic [63:0] best_due_r, best_due_nxt;
  logic [63:0] best_stamp_r, best_stamp_nxt;
  logic [63:0] best_val_r, best_val_nxt;
  logic [CNT_W-1:0] nfire_r, nfire_nxt;
  logic ovalid_r, ovalid_nxt;
  out_beat_t obeat_r, obeat_nxt;

  logic we;
  logic [TYPE_W-1:0] waddr, raddr;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic [63:0] r_due, r_val, r_stamp;

  tes_ram #(.WIDTH(ENTRY_W), .DEPTH(EVENT_TYPES)) u_slots (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign r_due   = rdata[191:128];
  assign r_val   = rdata[127:64];
  assign r_stamp = rdata[63:0];

  assign in_ready  = (state_r == ST_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = obeat_r;

  logic [63:0] dclamp, due_gap, late, used_add;
  logic signed [33:0] used;
  logic [19:0] cap_b, grant_v;
  logic in_range, better, ot_free;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    now_nxt = now_r;
    budget_nxt = budget_r;
    stamp_nxt = stamp_r;
    pend_nxt = pend_r;
    idx_nxt = idx_r;
    ridx_nxt = ridx_r;
    rvalid_nxt = 1'b0;
    found_nxt = found_r;
    best_nxt = best_r;
    best_due_nxt = best_due_r;
    best_stamp_nxt = best_stamp_r;
    best_val_nxt = best_val_r;
    nfire_nxt = nfire_r;
    obeat_nxt = obeat_r;
    we = 1'b0;
    waddr = op_r.slot_type[TYPE_W-1:0];
    dclamp = op_r.delay[63] ? 64'd0 : op_r.delay;
    wdata = {now_r + dclamp, op_r.user_value, stamp_r};
    raddr = idx_r[TYPE_W-1:0];
    ot_free = !ovalid_r || out_ready;
    ovalid_nxt = ovalid_r && !out_ready;
    in_range = ({1'b0, op_r.slot_type} < types_in_use) &&
               ({1'b0, op_r.slot_type} < 5'(EVENT_TYPES));
    better = !found_r || (r_due < best_due_r) ||
             ((r_due == best_due_r) && (r_stamp < best_stamp_r));
    used = 34'(signed'({1'b0, budget_r})) - 34'(op_r.cycles_left) -
           34'(op_r.exit_loss);
    used_add = 64'd0;
    due_gap = best_due_r - now_r;
    cap_b = (slice_cap != 0 && slice_cap < 31'(SLICE_LIMIT)) ?
            slice_cap[19:0] : SLICE_LIMIT;
    grant_v = cap_b;
    late = now_r - best_due_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          op_nxt = in_data;
          case (op_t'(in_data.opcode))
            OP_SCHEDULE, OP_REMOVE: state_nxt = ST_FIRE;
            OP_SLICE: state_nxt = ST_SCAN;
            default: begin
              state_nxt = ST_FIRE;
            end
          endcase
          idx_nxt = '0;
          found_nxt = 1'b0;
          nfire_nxt = '0;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, compare data from the previous read
        if (rvalid_r && pend_r[ridx_r] && better) begin
          found_nxt = 1'b1;
          best_nxt = ridx_r;
          best_due_nxt = r_due;
          best_stamp_nxt = r_stamp;
          best_val_nxt = r_val;
        end
        if (idx_r == CNT_W'(EVENT_TYPES)) begin
          state_nxt = ST_SCAN_WAIT;
        end else begin
          ridx_nxt = idx_r[TYPE_W-1:0];
          rvalid_nxt = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_SCAN_WAIT: begin
        if (ot_free) begin
          obeat_nxt = '0;
          obeat_nxt.time_now = now_r;
          if (op_t'(op_r.opcode) == OP_SLICE) begin
            if (found_r) begin
              if (due_gap[63]) grant_v = '0;
              else if (due_gap < {44'd0, cap_b}) grant_v = due_gap[19:0];
            end
            budget_nxt = grant_v;
            obeat_nxt.kind = KIND_GRANT;
            obeat_nxt.grant = grant_v;
            obeat_nxt.last = 1'b1;
            ovalid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else if (found_r && best_due_r <= now_r &&
                       nfire_r != CNT_W'(EVENT_TYPES)) begin
            pend_nxt[best_r] = 1'b0;
            obeat_nxt.kind = KIND_FIRED;
            obeat_nxt.fired_type = 4'(best_r);
            obeat_nxt.fired_value = best_val_r;
            obeat_nxt.lateness = (late > 64'(SLICE_LIMIT)) ? SLICE_LIMIT : late[19:0];
            ovalid_nxt = 1'b1;
            nfire_nxt = nfire_r + 1'b1;
            idx_nxt = '0;
            found_nxt = 1'b0;
            state_nxt = ST_SCAN;
          end else begin
            obeat_nxt.kind = KIND_DONE;
            obeat_nxt.last = 1'b1;
            ovalid_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FIRE: begin
        // update in ST_FIRE for schedule, remove and advance charge
        case (op_t'(op_r.opcode))
          OP_SCHEDULE: begin
            if (in_range) begin
              we = 1'b1;
              stamp_nxt = stamp_r + 64'd1;
              pend_nxt[op_r.slot_type[TYPE_W-1:0]] = 1'b1;
            end
            state_nxt = ST_IDLE;
          end
          OP_REMOVE: begin
            if (in_range) pend_nxt[op_r.slot_type[TYPE_W-1:0]] = 1'b0;
            state_nxt = ST_IDLE;
          end
          default: begin
            if (used < 0) used_add = 64'd0;
            else if (used > 34'(signed'({1'b0, budget_r}))) used_add = {44'd0, budget_r};
            else used_add = {44'd0, used[19:0]};
            now_nxt = now_r + used_add;
            budget_nxt = '0;
            state_nxt = ST_SCAN;
          end
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      now_r    <= '0;
      budget_r <= '0;
      stamp_r  <= '0;
      pend_r   <= '0;
      ovalid_r <= 1'b0;
      rvalid_r <= 1'b0;
      found_r  <= 1'b0;
      nfire_r  <= '0;
      idx_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      budget_r <= budget_nxt;
      stamp_r  <= stamp_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
      rvalid_r <= rvalid_nxt;
      found_r  <= found_nxt;
      nfire_r  <= nfire_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ridx_r       <= ridx_nxt;
    best_r       <= best_nxt;
    best_due_r   <= best_due_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_val_r   <= best_val_nxt;
    obeat_r      <= obeat_nxt;
  end

  `TES_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_r != ST_IDLE, !in_ready)
  `TES_ASSERT_NXT(a_fire_clears, clk, rst_n,
    state_r == ST_SCAN_WAIT && ot_free && state_nxt == ST_SCAN,
    !pend_r[best_r] && out_valid && out_data.kind == KIND_FIRED)
  `TES_ASSERT_IMP(a_nfire_bound, clk, rst_n, 1'b1, nfire_r <= CNT_W'(EVENT_TYPES))
  `TES_ASSERT_NXT(a_grant_budget, clk, rst_n,
    out_valid && out_ready && out_data.kind == KIND_GRANT,
    budget_r <= SLICE_LIMIT)
endmodule
